// ===== rtl/pbdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbdc_pkg
// Types, tables and constants shared by the band and divider calculator.
// ----------------------------------------------------------------------------
package pbdc_pkg;

  localparam int TABLE_SIZE           = 16;
  localparam int BAND_ENTRIES_DEFAULT = 16;
  localparam int IDX_W                = $clog2(TABLE_SIZE);

  localparam int FREQ_W = 22;
  localparam int KEEP_W = 2;
  localparam int CODE_W = 6;
  localparam int BYTE_W = 8;
  localparam int DIV_W  = 32;
  localparam int EXP_W  = 3;

  // 32000 = 2^8 * 125, so the divider is floor(freq * 2^(exp + 12) / 125)
  localparam int DIV_SMALL  = 125;
  localparam int SHIFT_BASE = 12;
  localparam int SHIFT_W    = 5;

  // freq / 125 by reciprocal: ceil(2^29 / 125)
  localparam int                RECIP_A_W     = 23;
  localparam logic [RECIP_A_W-1:0] RECIP_A    = 23'd4294968;
  localparam int                RECIP_A_SHIFT = 29;
  localparam int                PROD_A_W      = FREQ_W + RECIP_A_W;
  localparam int                QUOT_W        = 16;

  // remainder scaled, divided by 125: ceil(2^33 / 125)
  localparam int                REM_W         = 7;
  localparam int                REM_SH_W      = 26;
  localparam int                RECIP_B_W     = 27;
  localparam logic [RECIP_B_W-1:0] RECIP_B    = 27'd68719477;
  localparam int                RECIP_B_SHIFT = 33;
  localparam int                PROD_B_W      = REM_SH_W + RECIP_B_W;
  localparam int                FRAC_W        = 19;
  localparam int                SUM_W         = 36;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_khz;
    logic [KEEP_W-1:0] keep_bits;
    logic              device_index;
  } freq_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] band_code;
    logic [BYTE_W-1:0] band_reg_byte;
    logic [DIV_W-1:0]  divider_word;
    logic              above_table;
    logic              device_tag;
  } result_item_t;

  // after band search
  typedef struct packed {
    logic [FREQ_W-1:0]   freq_khz;
    logic [KEEP_W-1:0]   keep_bits;
    logic                device_index;
    logic [CODE_W-1:0]   band_code;
    logic                above_table;
    logic [PROD_A_W-1:0] quot_prod;
  } band_stage_t;

  // after quotient and remainder split
  typedef struct packed {
    logic [KEEP_W-1:0]   keep_bits;
    logic                device_index;
    logic [CODE_W-1:0]   band_code;
    logic                above_table;
    logic [QUOT_W-1:0]   quot;
    logic [REM_SH_W-1:0] rem_sh;
  } split_stage_t;

  // after fraction multiply
  typedef struct packed {
    logic [KEEP_W-1:0]   keep_bits;
    logic                device_index;
    logic [CODE_W-1:0]   band_code;
    logic                above_table;
    logic [QUOT_W-1:0]   quot;
    logic [PROD_B_W-1:0] frac_prod;
  } frac_stage_t;

  function automatic logic [FREQ_W-1:0] band_upper(input logic [IDX_W-1:0] idx);
    logic [FREQ_W-1:0] v;
    case (idx)
      4'd0:    v = 22'd285625;
      4'd1:    v = 22'd336875;
      4'd2:    v = 22'd405000;
      4'd3:    v = 22'd465000;
      4'd4:    v = 22'd571250;
      4'd5:    v = 22'd673750;
      4'd6:    v = 22'd810000;
      4'd7:    v = 22'd930000;
      4'd8:    v = 22'd1142500;
      4'd9:    v = 22'd1347500;
      4'd10:   v = 22'd1620000;
      4'd11:   v = 22'd1860000;
      4'd12:   v = 22'd2285000;
      4'd13:   v = 22'd2695000;
      4'd14:   v = 22'd3240000;
      default: v = 22'd3720000;
    endcase
    return v;
  endfunction

  function automatic logic [CODE_W-1:0] band_sel(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] v;
    case (idx)
      4'd0:    v = 6'h27;
      4'd1:    v = 6'h2F;
      4'd2:    v = 6'h37;
      4'd3:    v = 6'h3F;
      4'd4:    v = 6'h26;
      4'd5:    v = 6'h2E;
      4'd6:    v = 6'h36;
      4'd7:    v = 6'h3E;
      4'd8:    v = 6'h25;
      4'd9:    v = 6'h2D;
      4'd10:   v = 6'h35;
      4'd11:   v = 6'h3D;
      4'd12:   v = 6'h24;
      4'd13:   v = 6'h2C;
      4'd14:   v = 6'h34;
      default: v = 6'h3C;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/pbdc_band.sv =====
// ----------------------------------------------------------------------------
// pbdc_band
// First stage: band table search and frequency-by-125 reciprocal multiply.
// ----------------------------------------------------------------------------
module pbdc_band #(
  parameter int BAND_ENTRIES = pbdc_pkg::BAND_ENTRIES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    stall,
  input  pbdc_pkg::freq_item_t    item,
  output logic                    stage_valid,
  input  logic                    stage_stall,
  output pbdc_pkg::band_stage_t   stage
);
  import pbdc_pkg::*;

  logic [CODE_W-1:0] code;
  logic              above;
  logic              found;

  assign stall = stage_valid && stage_stall;

  always_comb begin
    code  = band_sel(IDX_W'(BAND_ENTRIES - 1));
    above = 1'b1;
    found = 1'b0;
    for (int i = 0; i < BAND_ENTRIES; i++) begin
      if (!found && (item.freq_khz < band_upper(IDX_W'(i)))) begin
        code  = band_sel(IDX_W'(i));
        above = 1'b0;
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!stall) begin
      stage_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      stage.freq_khz     <= item.freq_khz;
      stage.keep_bits    <= item.keep_bits;
      stage.device_index <= item.device_index;
      stage.band_code    <= code;
      stage.above_table  <= above;
      stage.quot_prod    <= PROD_A_W'(item.freq_khz) * PROD_A_W'(RECIP_A);
    end
  end

endmodule

// ===== rtl/pbdc_div.sv =====
// ----------------------------------------------------------------------------
// pbdc_div
// Divider stages: quotient/remainder split, fraction multiply, final
// sum with saturation into the output register.
// ----------------------------------------------------------------------------
module pbdc_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    stage_valid,
  output logic                    stage_stall,
  input  pbdc_pkg::band_stage_t   stage,
  output logic                    result_valid,
  input  logic                    result_stall,
  output pbdc_pkg::result_item_t  result_item
);
  import pbdc_pkg::*;

  split_stage_t      split;
  frac_stage_t       frac;
  logic              split_valid;
  logic              frac_valid;
  logic              split_stall;
  logic              frac_stall;
  logic              out_stall;

  logic [QUOT_W-1:0]  quot;
  logic [FREQ_W-1:0]  quot_x125;
  logic [REM_W-1:0]   rem;
  logic [SHIFT_W-1:0] shift_a;
  logic [SHIFT_W-1:0] shift_c;
  logic [FRAC_W-1:0]  frac_part;
  logic [SUM_W-1:0]   sum;

  assign out_stall   = result_valid && result_stall;
  assign frac_stall  = frac_valid && out_stall;
  assign split_stall = split_valid && frac_stall;
  assign stage_stall = split_stall;

  // stage 2
  always_comb begin
    quot      = stage.quot_prod[RECIP_A_SHIFT +: QUOT_W];
    quot_x125 = FREQ_W'(quot) * FREQ_W'(DIV_SMALL);
    rem       = REM_W'(stage.freq_khz - quot_x125);
    shift_a   = SHIFT_W'(stage.band_code[EXP_W-1:0]) + SHIFT_W'(SHIFT_BASE);
  end

  // stage 4
  always_comb begin
    shift_c   = SHIFT_W'(frac.band_code[EXP_W-1:0]) + SHIFT_W'(SHIFT_BASE);
    frac_part = frac.frac_prod[RECIP_B_SHIFT +: FRAC_W];
    sum       = (SUM_W'(frac.quot) << shift_c) + SUM_W'(frac_part);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split_valid  <= 1'b0;
      frac_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!split_stall) split_valid  <= stage_valid;
      if (!frac_stall)  frac_valid   <= split_valid;
      if (!out_stall)   result_valid <= frac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!split_stall) begin
      split.keep_bits    <= stage.keep_bits;
      split.device_index <= stage.device_index;
      split.band_code    <= stage.band_code;
      split.above_table  <= stage.above_table;
      split.quot         <= quot;
      split.rem_sh       <= REM_SH_W'(rem) << shift_a;
    end
    if (!frac_stall) begin
      frac.keep_bits    <= split.keep_bits;
      frac.device_index <= split.device_index;
      frac.band_code    <= split.band_code;
      frac.above_table  <= split.above_table;
      frac.quot         <= split.quot;
      frac.frac_prod    <= PROD_B_W'(split.rem_sh) * PROD_B_W'(RECIP_B);
    end
    if (!out_stall) begin
      result_item.band_code     <= frac.band_code;
      result_item.band_reg_byte <= {frac.band_code, frac.keep_bits};
      result_item.divider_word  <= (sum[SUM_W-1:DIV_W] != '0) ? '1 : sum[DIV_W-1:0];
      result_item.above_table   <= frac.above_table;
      result_item.device_tag    <= frac.device_index;
    end
  end

endmodule

// ===== rtl/pll_band_and_divider_calc.sv =====
// ----------------------------------------------------------------------------
// pll_band_and_divider_calc
// Synthesizer band selection and fractional-N divider calculation.
// ----------------------------------------------------------------------------
// Usage:
//   freq channel   : freq_valid / freq_stall / freq_item (frequency in kHz,
//                    two kept band-register bits, device index).
//   result channel : result_valid / result_stall / result_item (band code,
//                    packed band-register byte, 32-bit divider, above-table
//                    flag, device tag).
//   A transaction moves on a rising edge with valid high and stall low.
//   A transaction passes through four registered stages from acceptance to its
//   valid result: band search, quotient split, fraction multiply, sum into the
//   output register. One transaction is taken every cycle while freq_stall is
//   low; the 22x23 and 26x27 reciprocal multipliers each own a stage.
//   When result_stall is held, the stages fill up, empty stages keep taking
//   transactions, and freq_stall rises only once all four stages hold data.
//   Synchronous reset empties the pipeline; no results are pending after.
// ----------------------------------------------------------------------------
module pll_band_and_divider_calc #(
  parameter int BAND_ENTRIES = pbdc_pkg::BAND_ENTRIES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    freq_valid,
  output logic                    freq_stall,
  input  pbdc_pkg::freq_item_t    freq_item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output pbdc_pkg::result_item_t  result_item
);
  import pbdc_pkg::*;

  band_stage_t band_stage;
  logic        band_valid;
  logic        band_stall;

  pbdc_band #(
    .BAND_ENTRIES (BAND_ENTRIES)
  ) u_band (
    .clk         (clk),
    .rst         (rst),
    .valid       (freq_valid),
    .stall       (freq_stall),
    .item        (freq_item),
    .stage_valid (band_valid),
    .stage_stall (band_stall),
    .stage       (band_stage)
  );

  pbdc_div u_div (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (band_valid),
    .stage_stall  (band_stall),
    .stage        (band_stage),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

// ===== rtl/pbdc_checker.sv =====
// ----------------------------------------------------------------------------
// pbdc_checker
// Port-level checks for the band and divider calculator.
// ----------------------------------------------------------------------------
module pbdc_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    freq_valid,
  input  logic                    freq_stall,
  input  pbdc_pkg::freq_item_t    freq_item,
  input  logic                    result_valid,
  input  logic                    result_stall,
  input  pbdc_pkg::result_item_t  result_item
);
  import pbdc_pkg::*;

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // input only backs up when the output is held
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    freq_stall |-> (result_valid && result_stall))
    else $error("input stalled with output free");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result_item)))
    else $error("stalled result changed");

  // stalled input transaction is held by the sender
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (freq_valid && freq_stall) |=> (freq_valid && $stable(freq_item)))
    else $error("stalled input changed");

  // every table code has bit 5 set; byte carries the code
  a_byte_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.band_reg_byte[BYTE_W-1:KEEP_W] == result_item.band_code
                      && result_item.band_code[CODE_W-1]))
    else $error("band byte and code disagree");

endmodule

bind pll_band_and_divider_calc pbdc_checker u_pbdc_checker (
  .clk          (clk),
  .rst          (rst),
  .freq_valid   (freq_valid),
  .freq_stall   (freq_stall),
  .freq_item    (freq_item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
